FILE: design/ped_pkg.sv
// Shared types and constants for the particle Euler step block.
package ped_pkg;

    localparam logic REG_MAX_SPEED   = 1'b0;
    localparam logic REG_HALF_EXTENT = 1'b1;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    localparam int LANES = 3;

    // One stored particle: position and velocity, x/y/z, signed Q.F each.
    typedef struct packed {
        logic [LANES-1:0][31:0] pos;
        logic [LANES-1:0][31:0] vel;
    } ped_row_t;

    typedef struct packed {
        logic     en;
        ped_row_t row;
        logic [15:0] mass;
    } ped_wr_t;

endpackage

FILE: design/ped_mem.sv
// Particle table: row memory (position, velocity) and mass memory.
module ped_mem
    import ped_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  ped_wr_t       wr,
    input  logic [AW-1:0] wr_addr,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output ped_row_t      rd_row,
    output logic [15:0]   rd_mass
);

    ped_row_t    row_mem  [DEPTH];
    logic [15:0] mass_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            row_mem[wr_addr]  <= wr.row;
            mass_mem[wr_addr] <= wr.mass;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row  <= row_mem[rd_addr];
            rd_mass <= mass_mem[rd_addr];
        end
    end

endmodule

FILE: design/ped_div.sv
// Three-lane restoring divider with a shared divisor, one quotient bit per cycle.
module ped_div
    import ped_pkg::*;
#(
    parameter int DW = 63,
    parameter int VW = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [LANES-1:0][DW-1:0]  dividend,
    input  logic [VW-1:0]             divisor,
    output logic                      done,
    output logic [LANES-1:0][DW-1:0]  quo,
    output logic [LANES-1:0][VW-1:0]  rem
);

    localparam int CW = $clog2(DW + 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [VW-1:0]            den_reg, den_next;
    logic [LANES-1:0][DW-1:0] quo_reg, quo_next;
    logic [LANES-1:0][VW-1:0] rem_reg, rem_next;
    logic [LANES-1:0][VW:0]   sh;
    logic [LANES-1:0][VW:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        for (int i = 0; i < LANES; i++)
        begin
            sh[i]   = {rem_reg[i], quo_reg[i][DW-1]};
            diff[i] = sh[i] - {1'b0, den_reg};
        end
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            den_next  = divisor;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (!diff[i][VW])
                begin
                    rem_next[i] = diff[i][VW-1:0];
                    quo_next[i] = {quo_reg[i][DW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = sh[i][VW-1:0];
                    quo_next[i] = {quo_reg[i][DW-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

FILE: design/ped_sqrt.sv
// Bit-serial integer square root of a 64-bit value, two radicand bits per cycle.
module ped_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] rad_reg, rad_next;
    logic [34:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [34:0] sh;
    logic [34:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        sh        = {rem_reg[32:0], rad_reg[63:62]};
        trial     = {1'b0, root_reg, 2'b01};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[61:0], 2'b00};
            if (sh >= trial)
            begin
                rem_next  = sh - trial;
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = sh;
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: design/particle_euler_step_with_speed_clamp.sv
// Top level: particle table with explicit Euler update, speed clamp and y wrap.
//
// One item is processed at a time; the input stalls from acceptance until the
// result has been loaded into the output register, which then holds it while
// the next item is already taken. In an advance the shared three-lane
// bit-serial divider runs once for force/mass, once more when a nonzero speed
// is clamped and once for the wrap remainder when y wraps, and the bit-serial
// square root runs once for the speed. Index reduction subtracts
// PARTICLE_COUNT from the index until it is in range when the table has
// fewer than 256 entries. The particle state sits in a one-read, one-write
// memory with registered read data; entries read before they were loaded
// return undefined values.
module particle_euler_step_with_speed_clamp
    import ped_pkg::*;
#(
    parameter int PARTICLE_COUNT = 256,
    parameter int FRACTION_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  particle_index,
    input  logic signed [31:0] force_x,
    input  logic signed [31:0] force_y,
    input  logic signed [31:0] force_z,
    input  logic [31:0] step_time,
    input  logic [15:0] respawn_speed,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic [15:0] start_mass,
    input  logic [15:0] start_speed,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  result_index,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic        respawned,
    output logic        speed_clamped
);

    localparam int F  = FRACTION_BITS;
    localparam int IW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
    localparam int DW = 47 + F;
    localparam int HW = 16 + F;
    localparam int SW = DW + 3;
    localparam logic signed [SW-1:0] SAT_MAX = {{(SW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = {{(SW-31){1'b1}}, 31'b0};
    localparam logic [SW-1:0] TWO_31 = {{(SW-32){1'b0}}, 1'b1, 31'b0};

    typedef enum logic [23:0] {
        S_IDLE   = 24'h000001,
        S_INDEX  = 24'h000002,
        S_READ   = 24'h000004,
        S_FETCH  = 24'h000008,
        S_ASTART = 24'h000010,
        S_AWAIT  = 24'h000020,
        S_VMUL   = 24'h000040,
        S_VADD   = 24'h000080,
        S_SQMUL  = 24'h000100,
        S_SQACC  = 24'h000200,
        S_SSTART = 24'h000400,
        S_SWAIT  = 24'h000800,
        S_CHECK  = 24'h001000,
        S_CMUL   = 24'h002000,
        S_CSTART = 24'h004000,
        S_CWAIT  = 24'h008000,
        S_PMUL   = 24'h010000,
        S_PADD   = 24'h020000,
        S_WRAP   = 24'h040000,
        S_MSTART = 24'h080000,
        S_MWAIT  = 24'h100000,
        S_LOAD   = 24'h200000,
        S_WRITE  = 24'h400000,
        S_OUT    = 24'h800000
    } state_t;

    function automatic logic [31:0] sat32(input logic signed [SW-1:0] x);
        if (x > SAT_MAX)
            return 32'h7FFF_FFFF;
        if (x < SAT_MIN)
            return 32'h8000_0000;
        return x[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

    // a + sign * m, wide, signed result
    function automatic logic signed [SW-1:0] add_signed(input logic [31:0] a,
                                                      input logic [63:0] m,
                                                      input logic neg);
        logic [SW-1:0] ax;
        logic [SW-1:0] mx;
        ax = {{(SW-32){a[31]}}, a};
        mx = {{(SW-64){1'b0}}, m};
        return $signed(neg ? (ax - mx) : (ax + mx));
    endfunction

    function automatic logic [31:0] down_speed(input logic [15:0] s);
        logic [SW-1:0] m;
        logic [SW-1:0] n;
        m = {{(SW-HW){1'b0}}, s, {F{1'b0}}};
        n = ~m + 1'b1;
        if (m >= TWO_31)
            return 32'h8000_0000;
        return n[31:0];
    endfunction

    state_t state_reg, state_next;

    logic [15:0] max_speed_reg, max_speed_next;
    logic [15:0] half_extent_reg, half_extent_next;

    logic        action_reg, action_next;
    logic [7:0]  sel_reg, sel_next;
    logic [7:0]  sel_work_reg, sel_work_next;
    logic [LANES-1:0][31:0] force_reg, force_next;
    logic [LANES-1:0][31:0] start_reg, start_next;
    logic [31:0] t_reg, t_next;
    logic [15:0] resp_reg, resp_next;
    logic [15:0] smass_reg, smass_next;
    logic [15:0] sspeed_reg, sspeed_next;

    logic [LANES-1:0][31:0] pos_reg, pos_next;
    logic [LANES-1:0][31:0] vel_reg, vel_next;
    logic [15:0] mass_reg, mass_next;
    logic [LANES-1:0][31:0] acc_reg, acc_next;
    logic [1:0]  lane_reg, lane_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] sum_reg, sum_next;
    logic [31:0] speed_reg, speed_next;
    logic        clamp_reg, clamp_next;
    logic        resp_flag_reg, resp_flag_next;
    logic [HW-1:0] h_reg, h_next;

    logic [LANES-1:0][DW-1:0] num_reg, num_next;
    logic [31:0] den_reg, den_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_index_reg, out_index_next;
    logic [LANES-1:0][31:0] out_pos_reg, out_pos_next;
    logic        out_resp_reg, out_resp_next;
    logic        out_clamp_reg, out_clamp_next;

    logic [IW-1:0] idx;
    ped_wr_t     mem_wr;
    logic        mem_rd_en;
    ped_row_t    mem_rd_row;
    logic [15:0] mem_rd_mass;

    logic        div_start;
    logic        div_done;
    logic [LANES-1:0][DW-1:0] div_quo;
    logic [LANES-1:0][31:0]   div_rem;
    logic        sq_start;
    logic        sq_done;
    logic [31:0] sq_root;

    logic [31:0] vmag;
    logic [47:0] mprod;
    logic [SW-1:0] hx;
    logic [SW-1:0] ymag;
    logic [SW-1:0] qx;

    assign idx = IW'(sel_work_reg);

    ped_mem #(
        .DEPTH (PARTICLE_COUNT),
        .AW    (IW)
    ) u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .wr_addr (idx),
        .rd_en   (mem_rd_en),
        .rd_addr (idx),
        .rd_row  (mem_rd_row),
        .rd_mass (mem_rd_mass)
    );

    ped_div #(
        .DW (DW),
        .VW (32)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    ped_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sum_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign mem_rd_en = (state_reg == S_READ);
    assign div_start = (state_reg == S_ASTART) || (state_reg == S_CSTART) ||
                       (state_reg == S_MSTART);
    assign sq_start  = (state_reg == S_SSTART);

    always_comb
    begin
        mem_wr.en   = (state_reg == S_WRITE);
        mem_wr.row.pos = pos_reg;
        mem_wr.row.vel = vel_reg;
        mem_wr.mass = mass_reg;
    end

    assign vmag  = mag32(vel_reg[lane_reg]);
    assign mprod = 48'(vmag) * 48'(max_speed_reg);
    assign hx    = {{(SW-HW){1'b0}}, h_reg};
    assign ymag  = {{(SW-32){1'b0}}, mag32(pos_reg[1])};

    always_comb
    begin
        state_next       = state_reg;
        max_speed_next   = max_speed_reg;
        half_extent_next = half_extent_reg;
        action_next      = action_reg;
        sel_next         = sel_reg;
        sel_work_next    = sel_work_reg;
        force_next       = force_reg;
        start_next       = start_reg;
        t_next           = t_reg;
        resp_next        = resp_reg;
        smass_next       = smass_reg;
        sspeed_next      = sspeed_reg;
        pos_next         = pos_reg;
        vel_next         = vel_reg;
        mass_next        = mass_reg;
        acc_next         = acc_reg;
        lane_next        = lane_reg;
        prod_next        = prod_reg;
        sum_next         = sum_reg;
        speed_next       = speed_reg;
        clamp_next       = clamp_reg;
        resp_flag_next   = resp_flag_reg;
        h_next           = h_reg;
        num_next         = num_reg;
        den_next         = den_reg;
        out_valid_next   = out_valid_reg;
        out_index_next   = out_index_reg;
        out_pos_next     = out_pos_reg;
        out_resp_next    = out_resp_reg;
        out_clamp_next   = out_clamp_reg;
        qx               = '0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAX_SPEED:   max_speed_next   = cfg_data;
                REG_HALF_EXTENT: half_extent_next = cfg_data;
                default:         max_speed_next   = max_speed_reg;
            endcase
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    action_next    = action;
                    sel_next       = particle_index;
                    sel_work_next  = particle_index;
                    force_next     = {force_z, force_y, force_x};
                    start_next     = {start_z, start_y, start_x};
                    t_next         = step_time;
                    resp_next      = respawn_speed;
                    smass_next     = start_mass;
                    sspeed_next    = start_speed;
                    clamp_next     = 1'b0;
                    resp_flag_next = 1'b0;
                    state_next     = S_INDEX;
                end
            end
            S_INDEX:
            begin
                if (32'(sel_work_reg) >= PARTICLE_COUNT)
                    sel_work_next = sel_work_reg - 8'(PARTICLE_COUNT);
                else if (action_reg == ACT_LOAD)
                    state_next = S_LOAD;
                else
                    state_next = S_READ;
            end
            S_READ:
                state_next = S_FETCH;
            S_FETCH:
            begin
                pos_next  = mem_rd_row.pos;
                vel_next  = mem_rd_row.vel;
                mass_next = mem_rd_mass;
                for (int i = 0; i < LANES; i++)
                    num_next[i] = {{(DW-32){1'b0}}, mag32(force_reg[i])};
                den_next   = (mem_rd_mass == 16'd0) ? 32'd1 : {16'd0, mem_rd_mass};
                state_next = S_ASTART;
            end
            S_ASTART:
                state_next = S_AWAIT;
            S_AWAIT:
            begin
                if (div_done)
                begin
                    for (int i = 0; i < LANES; i++)
                        acc_next[i] = div_quo[i][31:0];
                    lane_next  = 2'd0;
                    state_next = S_VMUL;
                end
            end
            S_VMUL:
            begin
                prod_next  = 64'(acc_reg[lane_reg]) * 64'(t_reg);
                state_next = S_VADD;
            end
            S_VADD:
            begin
                vel_next[lane_reg] = sat32(add_signed(vel_reg[lane_reg], prod_reg >> F,
                                                      force_reg[lane_reg][31]));
                if (lane_reg == 2'd2)
                begin
                    lane_next  = 2'd0;
                    sum_next   = '0;
                    state_next = S_SQMUL;
                end
                else
                begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = S_VMUL;
                end
            end
            S_SQMUL:
            begin
                prod_next  = 64'(vmag) * 64'(vmag);
                state_next = S_SQACC;
            end
            S_SQACC:
            begin
                sum_next = sum_reg + prod_reg;
                if (lane_reg == 2'd2)
                begin
                    lane_next  = 2'd0;
                    state_next = S_SSTART;
                end
                else
                begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = S_SQMUL;
                end
            end
            S_SSTART:
                state_next = S_SWAIT;
            S_SWAIT:
            begin
                if (sq_done)
                begin
                    speed_next = sq_root;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                lane_next  = 2'd0;
                state_next = S_PMUL;
                if ({{(SW-32){1'b0}}, speed_reg} >=
                    {{(SW-HW){1'b0}}, max_speed_reg, {F{1'b0}}})
                begin
                    clamp_next = 1'b1;
                    if (speed_reg != 32'd0)
                        state_next = S_CMUL;
                end
            end
            S_CMUL:
            begin
                // |v| * limit = (|v| * max_speed) << F
                num_next[lane_reg] = {mprod[46:0], {F{1'b0}}};
                if (lane_reg == 2'd2)
                begin
                    lane_next  = 2'd0;
                    den_next   = speed_reg;
                    state_next = S_CSTART;
                end
                else
                    lane_next = lane_reg + 2'd1;
            end
            S_CSTART:
                state_next = S_CWAIT;
            S_CWAIT:
            begin
                if (div_done)
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        qx = {{(SW-DW){1'b0}}, div_quo[i]};
                        vel_next[i] = sat32($signed(vel_reg[i][31] ? (SW'(0) - qx) : qx));
                    end
                    lane_next  = 2'd0;
                    state_next = S_PMUL;
                end
            end
            S_PMUL:
            begin
                prod_next  = 64'(vmag) * 64'(t_reg);
                state_next = S_PADD;
            end
            S_PADD:
            begin
                pos_next[lane_reg] = sat32(add_signed(pos_reg[lane_reg], prod_reg >> F,
                                                      vel_reg[lane_reg][31]));
                if (lane_reg == 2'd2)
                begin
                    lane_next  = 2'd0;
                    h_next     = {((half_extent_reg == 16'd0) ? 16'd1 : half_extent_reg),
                                  {F{1'b0}}};
                    state_next = S_WRAP;
                end
                else
                begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = S_PMUL;
                end
            end
            S_WRAP:
            begin
                // y at or below -h; h is then at most 2^31 and fits the divisor
                if (pos_reg[1][31] && (ymag >= hx))
                begin
                    num_next[0] = {{(DW-32){1'b0}}, mag32(pos_reg[1])};
                    den_next    = hx[31:0];
                    state_next  = S_MSTART;
                end
                else
                    state_next = S_WRITE;
            end
            S_MSTART:
                state_next = S_MWAIT;
            S_MWAIT:
            begin
                if (div_done)
                begin
                    pos_next[1]    = sat32($signed(hx - {{(SW-32){1'b0}}, div_rem[0]}));
                    vel_next[0]    = 32'd0;
                    vel_next[1]    = down_speed(resp_reg);
                    vel_next[2]    = 32'd0;
                    resp_flag_next = 1'b1;
                    state_next     = S_WRITE;
                end
            end
            S_LOAD:
            begin
                pos_next    = start_reg;
                vel_next[0] = 32'd0;
                vel_next[1] = down_speed(sspeed_reg);
                vel_next[2] = 32'd0;
                mass_next   = smass_reg;
                state_next  = S_WRITE;
            end
            S_WRITE:
                state_next = S_OUT;
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = sel_reg;
                    out_pos_next   = pos_reg;
                    out_resp_next  = resp_flag_reg;
                    out_clamp_next = clamp_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            max_speed_reg   <= 16'd100;
            half_extent_reg <= 16'd100;
            out_valid_reg   <= 1'b0;
            lane_reg        <= 2'd0;
        end
        else
        begin
            state_reg       <= state_next;
            max_speed_reg   <= max_speed_next;
            half_extent_reg <= half_extent_next;
            out_valid_reg   <= out_valid_next;
            lane_reg        <= lane_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        sel_reg       <= sel_next;
        sel_work_reg  <= sel_work_next;
        force_reg     <= force_next;
        start_reg     <= start_next;
        t_reg         <= t_next;
        resp_reg      <= resp_next;
        smass_reg     <= smass_next;
        sspeed_reg    <= sspeed_next;
        pos_reg       <= pos_next;
        vel_reg       <= vel_next;
        mass_reg      <= mass_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        sum_reg       <= sum_next;
        speed_reg     <= speed_next;
        clamp_reg     <= clamp_next;
        resp_flag_reg <= resp_flag_next;
        h_reg         <= h_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        out_index_reg <= out_index_next;
        out_pos_reg   <= out_pos_next;
        out_resp_reg  <= out_resp_next;
        out_clamp_reg <= out_clamp_next;
    end

    assign out_valid     = out_valid_reg;
    assign result_index  = out_index_reg;
    assign pos_x         = $signed(out_pos_reg[0]);
    assign pos_y         = $signed(out_pos_reg[1]);
    assign pos_z         = $signed(out_pos_reg[2]);
    assign respawned     = out_resp_reg;
    assign speed_clamped = out_clamp_reg;

endmodule
